@@ sv/tsl_pkg.sv @@
// Shared types and codes for the triangle strip to list assembler.
// No dependencies; used by tsl_step, the top level and the checker.
package tsl_pkg;

  localparam int unsigned IdxW      = 16;
  localparam int unsigned StripW    = 15;
  localparam int unsigned MinStrip  = 3;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_TRI  = 2'd1,
    KIND_BAD  = 2'd2,
    KIND_DONE = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_V0     = 3'd1,
    PH_V1     = 3'd2,
    PH_V2     = 3'd3,
    PH_MORE   = 3'd4
  } phase_t;

  typedef struct packed {
    logic [IdxW-1:0]   older_index;
    logic [IdxW-1:0]   newer_index;
    logic [IdxW-1:0]   vertices_left;
    logic [StripW-1:0] strips_left;
    logic              reversed;
    phase_t            phase;
  } state_t;

  typedef struct packed {
    kind_t           kind;
    logic [IdxW-1:0] vertex_first;
    logic [IdxW-1:0] vertex_second;
    logic [IdxW-1:0] vertex_third;
    logic            final_triangle;
  } result_t;

endpackage

@@ sv/tsl_step.sv @@
// One assembly step: next state and result for one list word.
// Depends on tsl_pkg.
module tsl_step (
  input  tsl_pkg::state_t                st,
  input  logic [tsl_pkg::IdxW-1:0]       index_word,
  input  logic                           list_start,
  input  logic [tsl_pkg::StripW-1:0]     strip_total,
  output tsl_pkg::state_t                st_nxt,
  output tsl_pkg::result_t               res
);

  tsl_pkg::state_t         cur;
  logic [tsl_pkg::IdxW-1:0] vl_dec;

  always_comb begin
    // restart clears the list and reloads the strip count first
    cur = st;
    if (list_start) begin
      cur             = '0;
      cur.phase       = tsl_pkg::PH_HEADER;
      cur.strips_left = strip_total;
    end
    vl_dec = cur.vertices_left - tsl_pkg::IdxW'(1);
  end

  always_comb begin
    st_nxt = cur;
    res    = '0;
    res.kind = tsl_pkg::KIND_NONE;
    case (cur.phase)
      tsl_pkg::PH_V0: begin
        st_nxt.newer_index = index_word;
        st_nxt.phase       = tsl_pkg::PH_V1;
      end
      tsl_pkg::PH_V1: begin
        st_nxt.older_index = cur.newer_index;
        st_nxt.newer_index = index_word;
        st_nxt.phase       = tsl_pkg::PH_V2;
      end
      tsl_pkg::PH_V2: begin
        res.kind           = tsl_pkg::KIND_TRI;
        res.vertex_first   = cur.older_index;
        res.vertex_second  = cur.newer_index;
        res.vertex_third   = index_word;
        res.final_triangle = (cur.vertices_left == '0) && (cur.strips_left == '0);
        st_nxt.older_index = cur.newer_index;
        st_nxt.newer_index = index_word;
        st_nxt.reversed    = 1'b1;
        st_nxt.phase       = (cur.vertices_left != '0) ? tsl_pkg::PH_MORE
                                                       : tsl_pkg::PH_HEADER;
      end
      tsl_pkg::PH_MORE: begin
        res.kind           = tsl_pkg::KIND_TRI;
        res.vertex_first   = cur.reversed ? cur.newer_index : cur.older_index;
        res.vertex_second  = cur.reversed ? cur.older_index : cur.newer_index;
        res.vertex_third   = index_word;
        res.final_triangle = (vl_dec == '0) && (cur.strips_left == '0);
        st_nxt.older_index   = cur.newer_index;
        st_nxt.newer_index   = index_word;
        st_nxt.reversed      = ~cur.reversed;
        st_nxt.vertices_left = vl_dec;
        if (vl_dec == '0) begin
          st_nxt.phase = tsl_pkg::PH_HEADER;
        end
      end
      default: begin
        // header phase; unused phase codes fall back here too
        st_nxt.phase = tsl_pkg::PH_HEADER;
        if (cur.strips_left == '0) begin
          res.kind = tsl_pkg::KIND_DONE;
        end else if (index_word < tsl_pkg::IdxW'(tsl_pkg::MinStrip)) begin
          res.kind = tsl_pkg::KIND_BAD;
        end else begin
          st_nxt.vertices_left = index_word - tsl_pkg::IdxW'(tsl_pkg::MinStrip);
          st_nxt.strips_left   = cur.strips_left - tsl_pkg::StripW'(1);
          st_nxt.phase         = tsl_pkg::PH_V0;
        end
      end
    endcase
  end

endmodule

@@ sv/triangle_strip_to_list_core.sv @@
// Triangle strip to triangle list assembler, top level.
// Depends on tsl_pkg and tsl_step.
//
// Takes one list word per beat (strip length header or vertex index) and
// returns exactly one result beat per input beat: a triangle, a "consumed"
// marker, a bad-length error or a list-done marker. The assembly state
// updates at the input accept edge and the result lands in a two-deep
// output stage (output register plus skid register), so a new word is
// taken every cycle while the result side keeps up. A result goes to the
// skid register while the output register holds a stalled beat. in_stall
// rises only once the result side held off and the skid register filled.
// cfg_strip_total may be written at any time the block is idle; it is loaded
// into the strip counter by a beat that carries in_list_start.
module triangle_strip_to_list_core (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tsl_pkg::StripW-1:0]    cfg_strip_total,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tsl_pkg::IdxW-1:0]      in_index_word,
  input  logic                          in_list_start,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_kind,
  output logic [tsl_pkg::IdxW-1:0]      out_vertex_first,
  output logic [tsl_pkg::IdxW-1:0]      out_vertex_second,
  output logic [tsl_pkg::IdxW-1:0]      out_vertex_third,
  output logic                          out_final_triangle
);

  logic [tsl_pkg::StripW-1:0] strip_total_r;
  tsl_pkg::state_t            st_r;
  tsl_pkg::state_t            st_nxt;
  tsl_pkg::result_t           res;
  tsl_pkg::result_t           out_r;
  tsl_pkg::result_t           skid_r;
  logic                       out_valid_r;
  logic                       skid_valid_r;
  logic                       in_acc;
  logic                       out_free;

  // register write is always taken
  assign cfg_ready = 1'b1;

  // hold input off only when both result slots are full
  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !skid_valid_r;
  // output slot can take a new beat this cycle
  assign out_free = !out_valid_r || !out_stall;

  tsl_step u_step (
    .st          (st_r),
    .index_word  (in_index_word),
    .list_start  (in_list_start),
    .strip_total (strip_total_r),
    .st_nxt      (st_nxt),
    .res         (res)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strip_total_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      strip_total_r <= cfg_strip_total;
    end
  end

  // assembly state: advance on every accepted beat; all zero is the header phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (in_acc) begin
      st_r <= st_nxt;
    end
  end

  // output stage with skid: drain skid first, else load the fresh result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_r  <= skid_valid_r || in_acc;
        skid_valid_r <= 1'b0;
      end else if (in_acc) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (in_acc) begin
        out_r <= res;
      end
    end
    if (!out_free && in_acc) begin
      skid_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_r.kind;
  assign out_vertex_first   = out_r.vertex_first;
  assign out_vertex_second  = out_r.vertex_second;
  assign out_vertex_third   = out_r.vertex_third;
  assign out_final_triangle = out_r.final_triangle;

endmodule

@@ sv/tsl_checker.sv @@
// Port-level checks for triangle_strip_to_list_core, bound to the top level.
// Depends on tsl_pkg.
module tsl_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [1:0]                 out_kind,
  input logic [tsl_pkg::IdxW-1:0]   out_vertex_first,
  input logic [tsl_pkg::IdxW-1:0]   out_vertex_second,
  input logic [tsl_pkg::IdxW-1:0]   out_vertex_third,
  input logic                       out_final_triangle
);

  // a stalled result beat holds its kind, third vertex and final flag
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind)
      && $stable(out_vertex_third) && $stable(out_final_triangle))
    else $error("stalled result beat changed");

  // non-triangle beats carry zero vertices and no final flag
  a_non_tri_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != tsl_pkg::KIND_TRI) |->
      (out_vertex_first == '0) && (out_vertex_second == '0)
      && (out_vertex_third == '0) && !out_final_triangle)
    else $error("non-triangle beat with payload");

  // input side backs off only after the result side held a beat
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stalled without result backpressure");

  // an accepted beat is always followed by out_valid at the result port
  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted beat produced no result");

endmodule

bind triangle_strip_to_list_core tsl_checker u_tsl_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_kind           (out_kind),
  .out_vertex_first   (out_vertex_first),
  .out_vertex_second  (out_vertex_second),
  .out_vertex_third   (out_vertex_third),
  .out_final_triangle (out_final_triangle)
);

@@ bench/tsl_tb_pkg.sv @@
`timescale 1ns / 1ps
// Triangle assembly tracker for the strip to list bench: predicts each result beat.
// Depends on tsl_pkg for the widths, kind and phase codes and result_t.
package tsl_tb_pkg;

  class prim_tracker;
    logic [tsl_pkg::StripW-1:0] strip_total;
    logic [tsl_pkg::IdxW-1:0]   older;
    logic [tsl_pkg::IdxW-1:0]   newer;
    logic [tsl_pkg::IdxW-1:0]   verts_left;
    logic [tsl_pkg::StripW-1:0] strips_left;
    logic                       rev;
    tsl_pkg::phase_t            ph;
    tsl_pkg::result_t           prims_due[$];
    int unsigned                bad_prims;

    function new();
      strip_total = '0;
      bad_prims   = 0;
      clear();
    endfunction

    function void clear();
      older       = '0;
      newer       = '0;
      verts_left  = '0;
      strips_left = '0;
      rev         = 1'b0;
      ph          = tsl_pkg::PH_HEADER;
    endfunction

    function void load_total(input logic [tsl_pkg::StripW-1:0] v);
      strip_total = v;
    endfunction

    function int unsigned outstanding();
      return prims_due.size();
    endfunction

    // Advance the assembly state by one word and return the beat it yields.
    function tsl_pkg::result_t assemble(input logic [tsl_pkg::IdxW-1:0] w,
                                        input logic start);
      tsl_pkg::result_t r;
      r      = '0;
      r.kind = tsl_pkg::KIND_NONE;
      if (start) begin
        clear();
        strips_left = strip_total;
      end
      case (ph)
        tsl_pkg::PH_V0: begin
          newer = w;
          ph    = tsl_pkg::PH_V1;
        end
        tsl_pkg::PH_V1: begin
          older = newer;
          newer = w;
          ph    = tsl_pkg::PH_V2;
        end
        tsl_pkg::PH_V2: begin
          r.kind           = tsl_pkg::KIND_TRI;
          r.vertex_first   = older;
          r.vertex_second  = newer;
          r.vertex_third   = w;
          r.final_triangle = (verts_left == 0) && (strips_left == 0);
          older = newer;
          newer = w;
          rev   = 1'b1;
          ph    = (verts_left != 0) ? tsl_pkg::PH_MORE : tsl_pkg::PH_HEADER;
        end
        tsl_pkg::PH_MORE: begin
          // odd triangles swap the first two vertices to keep the winding
          r.kind          = tsl_pkg::KIND_TRI;
          r.vertex_first  = rev ? newer : older;
          r.vertex_second = rev ? older : newer;
          r.vertex_third  = w;
          older      = newer;
          newer      = w;
          rev        = ~rev;
          verts_left = verts_left - 1'b1;
          r.final_triangle = (verts_left == 0) && (strips_left == 0);
          if (verts_left == 0) ph = tsl_pkg::PH_HEADER;
        end
        default: begin
          ph = tsl_pkg::PH_HEADER;
          if (strips_left == 0) begin
            r.kind = tsl_pkg::KIND_DONE;
          end else if (w < tsl_pkg::MinStrip) begin
            r.kind = tsl_pkg::KIND_BAD;
          end else begin
            verts_left  = w - tsl_pkg::IdxW'(tsl_pkg::MinStrip);
            strips_left = strips_left - 1'b1;
            ph          = tsl_pkg::PH_V0;
          end
        end
      endcase
      return r;
    endfunction

    function void take_word(input logic [tsl_pkg::IdxW-1:0] w, input logic start);
      prims_due.push_back(assemble(w, start));
    endfunction

    function void match_prim(input tsl_pkg::result_t got);
      tsl_pkg::result_t want;
      if (prims_due.size() == 0) begin
        bad_prims++;
        if (bad_prims <= 10)
          $display("%0t: unexpected result beat: kind %0d (%h %h %h) final %b", $time,
                   got.kind, got.vertex_first, got.vertex_second, got.vertex_third,
                   got.final_triangle);
        return;
      end
      want = prims_due.pop_front();
      if (got.kind !== want.kind || got.vertex_first !== want.vertex_first ||
          got.vertex_second !== want.vertex_second ||
          got.vertex_third !== want.vertex_third ||
          got.final_triangle !== want.final_triangle) begin
        bad_prims++;
        if (bad_prims <= 10)
          $display("%0t: mismatch: exp %0d (%h %h %h) %b, got %0d (%h %h %h) %b",
                   $time, want.kind, want.vertex_first, want.vertex_second,
                   want.vertex_third, want.final_triangle, got.kind, got.vertex_first,
                   got.vertex_second, got.vertex_third, got.final_triangle);
      end
    endfunction
  endclass

endpackage

@@ bench/tb_triangle_strip_to_list_core.sv @@
`timescale 1ns / 1ps
// Top-level bench for triangle_strip_to_list_core: directed and random strip lists.
// Depends on tsl_pkg, tsl_tb_pkg (prim_tracker) and the core itself.
module tb_triangle_strip_to_list_core;

  localparam int unsigned RandomBeats   = 500;
  localparam int unsigned DirectedBeats = 26;
  // Longest correct quiet spell is a long sender gap or a long result stall
  // plus a drain; this is many times that.
  localparam int unsigned WatchdogLimit = 4000;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [tsl_pkg::StripW-1:0] cfg_strip_total = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [tsl_pkg::IdxW-1:0]   in_index_word = '0;
  logic                       in_list_start = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [1:0]                 out_kind;
  logic [tsl_pkg::IdxW-1:0]   out_vertex_first;
  logic [tsl_pkg::IdxW-1:0]   out_vertex_second;
  logic [tsl_pkg::IdxW-1:0]   out_vertex_third;
  logic                       out_final_triangle;

  tsl_tb_pkg::prim_tracker prims;
  int unsigned beats_sent = 0;
  int unsigned calm_beats = 0;
  int unsigned stuck_cycles = 0;

  triangle_strip_to_list_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_strip_total   (cfg_strip_total),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_index_word     (in_index_word),
    .in_list_start     (in_list_start),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_vertex_first  (out_vertex_first),
    .out_vertex_second (out_vertex_second),
    .out_vertex_third  (out_vertex_third),
    .out_final_triangle(out_final_triangle)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Sender gap before the next beat: mostly none, sometimes short, rarely
  // long. Now and then enter a calm stretch with no gaps at all.
  function automatic int unsigned sender_gap();
    int unsigned r;
    if (calm_beats != 0) begin
      calm_beats--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_beats = $urandom_range(20, 60);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Length of one result-side stall, never zero.
  function automatic int unsigned stall_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 10);
    return $urandom_range(20, 60);
  endfunction

  // Length of a run with the result side open; long runs give stall-free stretches.
  function automatic int unsigned open_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 6);
    if (r < 95) return $urandom_range(7, 30);
    return $urandom_range(60, 150);
  endfunction

  function automatic logic [tsl_pkg::IdxW-1:0] vertex_word();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    return 16'($urandom);
  endfunction

  // Strip length: mostly short strips, a few longer ones.
  function automatic logic [tsl_pkg::IdxW-1:0] strip_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 88) return 16'($urandom_range(3, 8));
    return 16'($urandom_range(9, 40));
  endfunction

  // Result side: alternate open runs and stalls, changing only at the falling edge.
  initial begin : stall_gen
    int unsigned hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold != 0) begin
        hold--;
      end else if (out_stall) begin
        out_stall <= 1'b0;
        hold = open_len() - 1;
      end else begin
        out_stall <= 1'b1;
        hold = stall_len() - 1;
      end
    end
  end

  // Sample at the rising edge: check result beats and watch for a hang.
  always @(posedge clk) begin : watch
    tsl_pkg::result_t seen;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        seen.kind           = tsl_pkg::kind_t'(out_kind);
        seen.vertex_first   = out_vertex_first;
        seen.vertex_second  = out_vertex_second;
        seen.vertex_third   = out_vertex_third;
        seen.final_triangle = out_final_triangle;
        prims.match_prim(seen);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
        if (stuck_cycles >= WatchdogLimit) begin
          $display("Regression FAIL");
          $finish;
        end
      end
    end
  end

  // Drive one list word: hold valid low for a random gap, then present the
  // beat and hold it until it is taken. Valid stays high into the next call
  // when that call picks no gap.
  task automatic send_beat(input logic [tsl_pkg::IdxW-1:0] word, input logic start);
    int unsigned gap;
    gap = sender_gap();
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_index_word <= word;
    in_list_start <= start;
    do @(posedge clk); while (in_stall);
    prims.take_word(word, start);
    beats_sent++;
  endtask

  // Drop valid and hold off until every predicted beat has come back.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (prims.outstanding() != 0) @(posedge clk);
  endtask

  // Write strip_total only with the core idle.
  task automatic write_total(input logic [tsl_pkg::StripW-1:0] v);
    drain();
    // slack after the drain before writing strip_total
    repeat (2) @(posedge clk);
    @(negedge clk);
    cfg_valid       <= 1'b1;
    cfg_strip_total <= v;
    do @(posedge clk); while (!cfg_ready);
    prims.load_total(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One list: restart on the first header, then well-formed strips with random
  // indices, an occasional bad header, a rare restart inside a strip, and a
  // few trailing words that report the list done once every configured strip was sent.
  task automatic run_list(input logic [tsl_pkg::StripW-1:0] total);
    int unsigned strips;
    logic [tsl_pkg::IdxW-1:0] len;
    logic start;
    if (total == 0) strips = 1;
    else if (total < 6) strips = total;
    else strips = $urandom_range(2, 5);
    start = 1'b1;
    for (int s = 0; s < strips; s++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_beat(16'($urandom_range(0, 2)), start);
        start = 1'b0;
      end
      len = strip_len();
      send_beat(len, start);
      start = 1'b0;
      for (int k = 0; k < len; k++) begin
        // abandon the strip: a following strip header, if any, restarts the whole list
        if ($urandom_range(0, 99) == 0) begin
          start = 1'b1;
          break;
        end
        send_beat(vertex_word(), 1'b0);
      end
      if ($urandom_range(0, 19) == 0) drain();
    end
    repeat ($urandom_range(1, 3)) send_beat(vertex_word(), 1'b0);
  endtask

  initial begin : main
    logic [tsl_pkg::StripW-1:0] total;
    int unsigned phase_no;
    prims = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part with two strips configured.
    write_total(15'd2);
    send_beat(16'd5, 1'b0);        // no restart yet: list is already done
    send_beat(16'd4, 1'b1);        // restart, strip of four
    send_beat(16'h0000, 1'b0);
    send_beat(16'hFFFF, 1'b0);
    send_beat(16'h1234, 1'b0);     // first triangle in order
    send_beat(16'hFFFF, 1'b0);     // second triangle, reversed winding
    send_beat(16'd0, 1'b0);        // bad lengths, all dropped
    send_beat(16'd2, 1'b0);
    send_beat(16'd1, 1'b0);
    send_beat(16'd3, 1'b0);        // exactly three: one triangle, last of list
    send_beat(16'h0007, 1'b0);
    send_beat(16'h8000, 1'b0);
    send_beat(16'hAAAA, 1'b0);
    send_beat(16'd9, 1'b0);        // past the last strip
    send_beat(16'd0, 1'b1);        // restart on a bad header
    send_beat(16'hFFFF, 1'b0);     // longest header
    send_beat(16'h5555, 1'b0);
    send_beat(16'hAAAA, 1'b0);
    send_beat(16'h0001, 1'b0);
    send_beat(16'hFFFE, 1'b0);
    send_beat(16'd5, 1'b1);        // restart in the middle of a strip
    send_beat(16'd0, 1'b0);
    send_beat(16'd1, 1'b0);
    send_beat(16'd2, 1'b0);
    send_beat(16'd3, 1'b0);
    send_beat(16'd4, 1'b0);

    // Random lists, each under a fresh strip_total; extremes come first.
    phase_no = 0;
    while (beats_sent < DirectedBeats + RandomBeats) begin
      case (phase_no)
        0:       total = '0;
        1:       total = '1;
        2:       total = 15'd1;
        default: total = ($urandom_range(0, 9) == 0) ? 15'($urandom)
                                                     : 15'($urandom_range(1, 6));
      endcase
      write_total(total);
      run_list(total);
      // raw noise: any word, restart now and then
      if ($urandom_range(0, 7) == 0)
        repeat ($urandom_range(3, 10))
          send_beat(16'($urandom), $urandom_range(0, 7) == 0);
      phase_no++;
    end

    drain();
    repeat (8) @(posedge clk);
    if (prims.bad_prims == 0 && prims.outstanding() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/tsl_pkg.sv
sv/tsl_step.sv
sv/triangle_strip_to_list_core.sv
sv/tsl_checker.sv
bench/tsl_tb_pkg.sv
bench/tb_triangle_strip_to_list_core.sv
